/* sv/cnms_pkg.sv */
// Package: sizes, types and helpers for corner non-maximum suppression.
package cnms_pkg;

  localparam int ROW_CORNERS = 32;
  localparam int COORD_BITS  = 12;
  localparam int SCORE_BITS  = 32;
  localparam int MAX_RESULTS = 64;
  localparam int NROWS       = 3;

  localparam int CNT_W  = $clog2(ROW_CORNERS + 1);
  localparam int IDX_W  = $clog2(ROW_CORNERS);
  localparam int RS_D   = NROWS * ROW_CORNERS;
  localparam int RS_AW  = $clog2(RS_D);
  localparam int RS_W   = COORD_BITS + SCORE_BITS;
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int RB_AW  = $clog2(MAX_RESULTS);
  localparam int RB_W   = 2 * COORD_BITS + SCORE_BITS;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic [COORD_BITS:0]          coord_ext_t;
  typedef logic signed [SCORE_BITS-1:0] score_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [1:0]                   slot_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_CENT, S_CENT_D, S_SCAN, S_CMP, S_EMIT, S_UPD,
    S_ORD, S_OLD, S_OWAIT
  } state_t;

  // How a new corner relates to the newest held row.
  typedef enum logic [1:0] {K_SAME, K_BACK, K_NEW} kind_t;

  // Which row is being scanned against the centre corner.
  typedef enum logic [1:0] {G_SAME, G_UP, G_DN} grp_t;

  function automatic logic [RS_AW-1:0] rs_addr(input slot_t bank,
                                               input logic [IDX_W-1:0] idx);
    return RS_AW'(bank) * RS_AW'(ROW_CORNERS) + RS_AW'(idx);
  endfunction

endpackage

/* sv/corner_nonmax_suppression_top.sv */
// Top level of the 3x3 corner non-maximum suppression block.
//
//   channel | beat contents                                     | handshake
//   in_     | x_pos, y_pos, corner_score, final_corner           | in_valid / in_stall
//   out_    | kept_x, kept_y, kept_score, run_end, row_overflow   | out_valid / out_stall
//
// One beat is worked on at a time; in_stall stays high until its last result is taken.
// An item visits each held row and then updates the rows held; a last corner adds a
// flush pass over the rows then held. Each corner in a decided row is compared with the
// entries of its own row and of the rows above and below it, and stops at the first that
// beats it; a survivor is written to the result buffer. Each result is read from the
// result buffer through its registered read port and waits while out_stall is high.
// rst_n is synchronous; the row store needs no clearing pass.
module corner_nonmax_suppression_top
  import cnms_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  coord_t in_x_pos,
  input  coord_t in_y_pos,
  input  score_t in_corner_score,
  input  logic   in_final_corner,
  output logic   out_valid,
  input  logic   out_stall,
  output coord_t out_kept_x,
  output coord_t out_kept_y,
  output score_t out_kept_score,
  output logic   out_run_end,
  output logic   out_row_overflow
);

  state_t state_r, state_nxt;

  coord_t x_r, x_nxt, y_r, y_nxt;
  score_t s_r, s_nxt;
  logic   fin_r, fin_nxt, post_r, post_nxt;
  kind_t  kind_r, kind_nxt;

  coord_t num_r [NROWS];
  coord_t num_nxt [NROWS];
  cnt_t   cnt_r [NROWS];
  cnt_t   cnt_nxt [NROWS];
  slot_t  bank_r [NROWS];
  slot_t  bank_nxt [NROWS];
  slot_t  n_r, n_nxt;

  slot_t  si_r, si_nxt;
  cnt_t   j_r, j_nxt, k_r, k_nxt;
  grp_t   grp_r, grp_nxt;
  logic   up_ok_r, up_ok_nxt, dn_ok_r, dn_ok_nxt;
  slot_t  up_r, up_nxt, dn_r, dn_nxt;
  coord_t cx_r, cx_nxt;
  score_t cs_r, cs_nxt;

  logic [RES_W-1:0] res_n_r, res_n_nxt, o_r, o_nxt;
  logic             ovf_r, ovf_nxt;

  logic   out_valid_r, out_valid_nxt, run_end_r, run_end_nxt, oflag_r, oflag_nxt;
  coord_t kx_r, kx_nxt, ky_r, ky_nxt;
  score_t ks_r, ks_nxt;

  // memory ports
  logic             rs_we;
  logic [RS_AW-1:0] rs_waddr, rs_raddr;
  logic [RS_W-1:0]  rs_wdata, rs_rdata;
  logic             rb_we;
  logic [RB_W-1:0]  rb_wdata, rb_rdata;

  // decode
  slot_t      slot_ix, lst_ix, free_bank, drop_n, keep_n;
  coord_t     newest, cur_num;
  kind_t      kind_in;
  logic       row_mask, beat;
  cnt_t       gcnt;
  slot_t      gbank;
  logic       up_ok_c, dn_ok_c;
  slot_t      up_c, dn_c;
  coord_t     rx;
  score_t     rsc;
  coord_ext_t rx_e, rx1, cx_e, cx1;

  cnms_ram #(.WIDTH(RS_W), .DEPTH(RS_D)) u_row_store (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  cnms_ram #(.WIDTH(RB_W), .DEPTH(MAX_RESULTS)) u_result_buf (
    .clk   (clk),
    .we    (rb_we),
    .waddr (res_n_r[RB_AW-1:0]),
    .wdata (rb_wdata),
    .raddr (o_r[RB_AW-1:0]),
    .rdata (rb_rdata)
  );

  always_comb begin
    logic [NROWS-1:0] used;
    int i;
    slot_t d;
    slot_t m;

    slot_ix = (si_r == 2'd3) ? 2'd2 : si_r;
    lst_ix  = (n_r == 2'd0) ? 2'd0 : n_r - 2'd1;
    newest  = num_r[lst_ix];
    cur_num = num_r[slot_ix];

    if (n_r != 2'd0 && in_y_pos == newest) begin
      kind_in = K_SAME;
    end else if (n_r != 2'd0 && in_y_pos < newest) begin
      kind_in = K_BACK;
    end else begin
      kind_in = K_NEW;
    end

    // Rows within one of the newest are decided; a new row must also lie two or more past them.
    if (post_r || kind_r == K_BACK) begin
      row_mask = ({1'b0, cur_num} + 13'(1)) >= {1'b0, newest};
    end else if (kind_r == K_NEW) begin
      row_mask = (({1'b0, cur_num} + 13'(1)) >= {1'b0, newest}) &&
                 (({1'b0, cur_num} + 13'(2)) <= {1'b0, y_r});
    end else begin
      row_mask = 1'b0;
    end

    up_ok_c = 1'b0;
    up_c    = 2'd0;
    dn_ok_c = 1'b0;
    dn_c    = 2'd0;
    for (i = 0; i < NROWS; i++) begin
      if (slot_t'(i) < n_r) begin
        if ({1'b0, num_r[i]} + 13'(1) == {1'b0, cur_num}) begin
          up_ok_c = 1'b1;
          up_c    = slot_t'(i);
        end
        if ({1'b0, num_r[i]} == {1'b0, cur_num} + 13'(1)) begin
          dn_ok_c = 1'b1;
          dn_c    = slot_t'(i);
        end
      end
    end

    case (grp_r)
      G_SAME: begin
        gcnt  = cnt_r[slot_ix];
        gbank = bank_r[slot_ix];
      end
      G_UP: begin
        gcnt  = up_ok_r ? cnt_r[up_r] : '0;
        gbank = bank_r[up_r];
      end
      G_DN: begin
        gcnt  = dn_ok_r ? cnt_r[dn_r] : '0;
        gbank = bank_r[dn_r];
      end
      default: begin
        gcnt  = '0;
        gbank = 2'd0;
      end
    endcase

    rx   = rs_rdata[RS_W-1:SCORE_BITS];
    rsc  = $signed(rs_rdata[SCORE_BITS-1:0]);
    rx_e = {1'b0, rx};
    rx1  = rx_e + 13'(1);
    cx_e = {1'b0, cx_r};
    cx1  = cx_e + 13'(1);
    case (grp_r)
      G_SAME:  beat = (rx1 == cx_e && cs_r <= rsc) || (rx_e == cx1 && cs_r < rsc);
      G_UP:    beat = rx1 >= cx_e && rx_e <= cx1 && cs_r <= rsc;
      G_DN:    beat = rx1 >= cx_e && rx_e <= cx1 && cs_r < rsc;
      default: beat = 1'b0;
    endcase

    // Rows three or more below the new one leave; a full set loses its oldest; going back keeps none.
    d = 2'd0;
    for (i = 0; i < NROWS; i++) begin
      if (slot_t'(i) < n_r && ({1'b0, num_r[i]} + 13'(2)) < {1'b0, y_r}) begin
        d = d + 2'd1;
      end
    end
    m = n_r - d;
    if (m == 2'd3) begin
      d = d + 2'd1;
      m = 2'd2;
    end
    if (kind_r == K_BACK) begin
      m = 2'd0;
    end
    drop_n = d;
    keep_n = m;

    used = '0;
    for (i = 0; i < NROWS; i++) begin
      if (slot_t'(i) < m) begin
        used[bank_r[slot_t'(i) + d]] = 1'b1;
      end
    end
    free_bank = 2'd0;
    for (i = NROWS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_bank = slot_t'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        if (si_r == n_r) begin
          if (!post_r) begin
            state_nxt = S_UPD;
          end else begin
            state_nxt = (res_n_r == '0) ? S_IDLE : S_ORD;
          end
        end else if (row_mask) begin
          state_nxt = S_CENT;
        end
      end
      S_CENT: begin
        state_nxt = (j_r == cnt_r[slot_ix]) ? S_ROW : S_CENT_D;
      end
      S_CENT_D: state_nxt = S_SCAN;
      S_SCAN: begin
        if (k_r == gcnt) begin
          if (grp_r == G_DN) begin
            state_nxt = S_EMIT;
          end
        end else if (!(grp_r == G_SAME && k_r == j_r)) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: state_nxt = beat ? S_CENT : S_SCAN;
      S_EMIT: state_nxt = S_CENT;
      S_UPD: begin
        if (fin_r) begin
          state_nxt = S_ROW;
        end else begin
          state_nxt = (res_n_r == '0) ? S_IDLE : S_ORD;
        end
      end
      S_ORD: state_nxt = S_OLD;
      S_OLD: state_nxt = S_OWAIT;
      S_OWAIT: begin
        if (!out_stall) begin
          state_nxt = (RES_W'(o_r + RES_W'(1)) == res_n_r) ? S_IDLE : S_ORD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_stall = (state_r != S_IDLE);
    rs_raddr = (state_r == S_CENT) ? rs_addr(bank_r[slot_ix], j_r[IDX_W-1:0])
                                   : rs_addr(gbank, k_r[IDX_W-1:0]);
    rs_we    = 1'b0;
    rs_waddr = rs_addr(free_bank, '0);
    rs_wdata = {x_r, s_r};
    if (state_r == S_UPD) begin
      if (kind_r == K_SAME) begin
        rs_waddr = rs_addr(bank_r[lst_ix], cnt_r[lst_ix][IDX_W-1:0]);
        rs_we    = cnt_r[lst_ix] < CNT_W'(ROW_CORNERS);
      end else begin
        rs_we = 1'b1;
      end
    end
    rb_we    = (state_r == S_EMIT) && (res_n_r < RES_W'(MAX_RESULTS));
    rb_wdata = {cur_num, cx_r, cs_r};
  end

  // datapath registers
  always_comb begin
    int i;
    x_nxt = x_r; y_nxt = y_r; s_nxt = s_r; fin_nxt = fin_r;
    kind_nxt = kind_r; post_nxt = post_r;
    num_nxt = num_r; cnt_nxt = cnt_r; bank_nxt = bank_r; n_nxt = n_r;
    si_nxt = si_r; j_nxt = j_r; k_nxt = k_r; grp_nxt = grp_r;
    up_ok_nxt = up_ok_r; up_nxt = up_r; dn_ok_nxt = dn_ok_r; dn_nxt = dn_r;
    cx_nxt = cx_r; cs_nxt = cs_r;
    res_n_nxt = res_n_r; o_nxt = o_r; ovf_nxt = ovf_r;
    out_valid_nxt = out_valid_r; run_end_nxt = run_end_r; oflag_nxt = oflag_r;
    kx_nxt = kx_r; ky_nxt = ky_r; ks_nxt = ks_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_x_pos;
          y_nxt     = in_y_pos;
          s_nxt     = in_corner_score;
          fin_nxt   = in_final_corner;
          kind_nxt  = kind_in;
          post_nxt  = 1'b0;
          si_nxt    = 2'd0;
          res_n_nxt = '0;
          o_nxt     = '0;
        end
      end
      S_ROW: begin
        if (si_r == n_r) begin
          if (post_r) begin
            n_nxt = 2'd0;
          end
        end else if (row_mask) begin
          j_nxt     = '0;
          up_ok_nxt = up_ok_c;
          up_nxt    = up_c;
          dn_ok_nxt = dn_ok_c;
          dn_nxt    = dn_c;
        end else begin
          si_nxt = si_r + 2'd1;
        end
      end
      S_CENT: begin
        if (j_r == cnt_r[slot_ix]) begin
          si_nxt = si_r + 2'd1;
        end
      end
      S_CENT_D: begin
        cx_nxt  = rs_rdata[RS_W-1:SCORE_BITS];
        cs_nxt  = $signed(rs_rdata[SCORE_BITS-1:0]);
        grp_nxt = G_SAME;
        k_nxt   = '0;
      end
      S_SCAN: begin
        if (k_r == gcnt) begin
          k_nxt = '0;
          if (grp_r == G_SAME) begin
            grp_nxt = G_UP;
          end else if (grp_r == G_UP) begin
            grp_nxt = G_DN;
          end
        end else if (grp_r == G_SAME && k_r == j_r) begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      S_CMP: begin
        if (beat) begin
          j_nxt = j_r + CNT_W'(1);
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (res_n_r < RES_W'(MAX_RESULTS)) begin
          res_n_nxt = res_n_r + RES_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        j_nxt = j_r + CNT_W'(1);
      end
      S_UPD: begin
        if (kind_r == K_SAME) begin
          if (cnt_r[lst_ix] < CNT_W'(ROW_CORNERS)) begin
            cnt_nxt[lst_ix] = cnt_r[lst_ix] + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end else begin
          for (i = 0; i < NROWS; i++) begin
            if (slot_t'(i) < keep_n) begin
              num_nxt[i]  = num_r[slot_t'(i) + drop_n];
              cnt_nxt[i]  = cnt_r[slot_t'(i) + drop_n];
              bank_nxt[i] = bank_r[slot_t'(i) + drop_n];
            end
          end
          num_nxt[keep_n]  = y_r;
          cnt_nxt[keep_n]  = CNT_W'(1);
          bank_nxt[keep_n] = free_bank;
          n_nxt            = keep_n + 2'd1;
        end
        post_nxt = 1'b1;
        si_nxt   = 2'd0;
      end
      S_OLD: begin
        ky_nxt        = rb_rdata[RB_W-1:COORD_BITS+SCORE_BITS];
        kx_nxt        = rb_rdata[COORD_BITS+SCORE_BITS-1:SCORE_BITS];
        ks_nxt        = $signed(rb_rdata[SCORE_BITS-1:0]);
        run_end_nxt   = RES_W'(o_r + RES_W'(1)) == res_n_r;
        oflag_nxt     = ovf_r;
        out_valid_nxt = 1'b1;
      end
      S_OWAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          o_nxt         = o_r + RES_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= 2'd0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      res_n_r     <= '0;
      o_r         <= '0;
      si_r        <= 2'd0;
      post_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      res_n_r     <= res_n_nxt;
      o_r         <= o_nxt;
      si_r        <= si_nxt;
      post_r      <= post_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    s_r       <= s_nxt;
    fin_r     <= fin_nxt;
    kind_r    <= kind_nxt;
    num_r     <= num_nxt;
    cnt_r     <= cnt_nxt;
    bank_r    <= bank_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    grp_r     <= grp_nxt;
    up_ok_r   <= up_ok_nxt;
    up_r      <= up_nxt;
    dn_ok_r   <= dn_ok_nxt;
    dn_r      <= dn_nxt;
    cx_r      <= cx_nxt;
    cs_r      <= cs_nxt;
    run_end_r <= run_end_nxt;
    oflag_r   <= oflag_nxt;
    kx_r      <= kx_nxt;
    ky_r      <= ky_nxt;
    ks_r      <= ks_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kept_x       = kx_r;
  assign out_kept_y       = ky_r;
  assign out_kept_score   = ks_r;
  assign out_run_end      = run_end_r;
  assign out_row_overflow = oflag_r;

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_n_r <= RES_W'(MAX_RESULTS))
    else $error("result count beyond buffer depth");

  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 2'd3)
    else $error("more rows held than row banks");

  a_rows_order: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r >= 2'd2) |-> (num_r[0] < num_r[1]))
    else $error("held rows out of order");

  a_banks_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r >= 2'd2) |-> (bank_r[0] != bank_r[1]))
    else $error("two held rows share a bank");

  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("input taken while a result is pending");

endmodule

/* sv/cnms_ram.sv */
// Generic single-write, single-read memory with a registered read.
module cnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* bench/corner_nonmax_suppression_checker.sv */
// Checker: predicts surviving corners from accepted input beats and compares output beats.
module corner_nonmax_suppression_checker
  import cnms_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_stall,
  input  coord_t in_x_pos,
  input  coord_t in_y_pos,
  input  score_t in_corner_score,
  input  logic   in_final_corner,
  input  logic   out_valid,
  input  logic   out_stall,
  input  coord_t out_kept_x,
  input  coord_t out_kept_y,
  input  score_t out_kept_score,
  input  logic   out_run_end,
  input  logic   out_row_overflow,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    coord_t kx;
    coord_t ky;
    score_t ks;
    logic   re;
    logic   ov;
  } survivor_t;

  survivor_t survivor_q[$];
  survivor_t step_q[$];

  int     row_x[NROWS][ROW_CORNERS];
  score_t row_s[NROWS][ROW_CORNERS];
  int     row_num[NROWS];
  int     row_cnt[NROWS];
  logic   ovf;

  function automatic int rows_held();
    int n = 0;
    while (n < NROWS && row_cnt[n] != 0) n++;
    return n;
  endfunction

  function automatic int slot_of(int num, int n);
    for (int i = 0; i < n; i++) if (row_num[i] == num) return i;
    return -1;
  endfunction

  function automatic bit row_beats(int nb, int x, score_t s, bit ties_win);
    for (int k = 0; k < row_cnt[nb]; k++)
      if (row_x[nb][k] + 1 >= x && row_x[nb][k] <= x + 1)
        if (ties_win ? (s <= row_s[nb][k]) : (s < row_s[nb][k])) return 1;
    return 0;
  endfunction

  task automatic decide(int slot, int n);
    int rn, up, dn, x;
    score_t s;
    bit beaten;
    survivor_t e;
    rn = row_num[slot];
    up = (rn > 0) ? slot_of(rn - 1, n) : -1;
    dn = slot_of(rn + 1, n);
    for (int j = 0; j < row_cnt[slot]; j++) begin
      x = row_x[slot][j];
      s = row_s[slot][j];
      beaten = 0;
      for (int k = 0; k < row_cnt[slot] && !beaten; k++) begin
        if (k == j) continue;
        if (row_x[slot][k] + 1 == x && s <= row_s[slot][k]) beaten = 1;
        if (row_x[slot][k] == x + 1 && s < row_s[slot][k]) beaten = 1;
      end
      if (!beaten && up >= 0) beaten = row_beats(up, x, s, 1);
      if (!beaten && dn >= 0) beaten = row_beats(dn, x, s, 0);
      if (!beaten) begin
        if (step_q.size() >= MAX_RESULTS) begin
          ovf = 1;
        end else begin
          e.kx = coord_t'(x);
          e.ky = coord_t'(rn);
          e.ks = s;
          e.re = 0;
          e.ov = 0;
          step_q = {step_q, e};
        end
      end
    end
  endtask

  task automatic drop_row(int slot, int n);
    for (int i = slot; i + 1 < n; i++) begin
      row_x[i] = row_x[i+1];
      row_s[i] = row_s[i+1];
      row_num[i] = row_num[i+1];
      row_cnt[i] = row_cnt[i+1];
    end
    row_cnt[n-1] = 0;
    row_num[n-1] = 0;
  endtask

  task automatic clear_all();
    for (int i = 0; i < NROWS; i++) begin
      row_cnt[i] = 0;
      row_num[i] = 0;
    end
  endtask

  task automatic flush_all();
    int n, newest;
    n = rows_held();
    if (n > 0) begin
      newest = row_num[n-1];
      for (int i = 0; i < n; i++) if (row_num[i] + 1 >= newest) decide(i, n);
    end
    clear_all();
  endtask

  task automatic predict_corner(int x, int y, score_t s, bit fin);
    int n, i, newest;
    step_q.delete();
    n = rows_held();
    if (n > 0 && y == row_num[n-1]) begin
      if (row_cnt[n-1] < ROW_CORNERS) begin
        row_x[n-1][row_cnt[n-1]] = x;
        row_s[n-1][row_cnt[n-1]] = s;
        row_cnt[n-1]++;
      end else begin
        ovf = 1;
      end
    end else begin
      if (n > 0 && y < row_num[n-1]) begin
        flush_all();
        n = 0;
      end else if (n > 0) begin
        newest = row_num[n-1];
        for (i = 0; i < n; i++)
          if (row_num[i] + 1 >= newest && row_num[i] + 2 <= y) decide(i, n);
        i = 0;
        while (i < n) begin
          if (row_num[i] + 2 < y) begin
            drop_row(i, n);
            n--;
          end else begin
            i++;
          end
        end
      end
      if (n >= NROWS) begin
        drop_row(0, n);
        n--;
      end
      row_num[n] = y;
      row_cnt[n] = 1;
      row_x[n][0] = x;
      row_s[n][0] = s;
    end
    if (fin) flush_all();
    for (i = 0; i < step_q.size(); i++) begin
      step_q[i].re = (i == step_q.size() - 1);
      step_q[i].ov = ovf;
      survivor_q = {survivor_q, step_q[i]};
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    ovf = 0;
    clear_all();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      ovf = 0;
      clear_all();
      survivor_q.delete();
    end else begin
      if (in_valid && !in_stall)
        predict_corner(int'(in_x_pos), int'(in_y_pos), in_corner_score, in_final_corner);
      if (out_valid && !out_stall) begin
        if (survivor_q.size() == 0) begin
          $display("unexpected output beat x=%0d y=%0d at %0t", out_kept_x, out_kept_y,
                   $realtime);
          fail_count++;
        end else begin
          survivor_t w;
          w = survivor_q.pop_front();
          if (out_kept_x !== w.kx) report("kept_x", out_kept_x, w.kx);
          if (out_kept_y !== w.ky) report("kept_y", out_kept_y, w.ky);
          if (out_kept_score !== w.ks) report("kept_score", out_kept_score, w.ks);
          if (out_run_end !== w.re) report("run_end", out_run_end, w.re);
          if (out_row_overflow !== w.ov) report("row_overflow", out_row_overflow, w.ov);
        end
      end
    end
    pending = survivor_q.size();
  end

endmodule

/* bench/corner_nonmax_suppression_top_test.sv */
// Testbench top: drives corner beats with random gaps and output stalls, gives the verdict.
module corner_nonmax_suppression_top_test;
  import cnms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 100000;

  logic   clk = 0;
  logic   rst_n = 0;
  logic   in_valid = 0;
  logic   in_stall;
  coord_t in_x_pos = '0;
  coord_t in_y_pos = '0;
  score_t in_corner_score = '0;
  logic   in_final_corner = 0;
  logic   out_valid;
  logic   out_stall = 0;
  coord_t out_kept_x;
  coord_t out_kept_y;
  score_t out_kept_score;
  logic   out_run_end;
  logic   out_row_overflow;
  int     fail_count;
  int     pending;
  int     idle_cycles = 0;
  int     sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  corner_nonmax_suppression_top uut (.*);

  corner_nonmax_suppression_checker chk (.*);

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: bursts of ready and stall, one long hold-off to fill the block.
  initial begin
    int burst_left, cyc;
    logic burst_val;
    burst_left = 0;
    burst_val = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 400 && cyc < 1000) begin
        out_stall <= 1;
      end else begin
        if (burst_left == 0) begin
          burst_val = ($urandom_range(0, 99) < 40);
          if (burst_val && $urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
          else burst_left = $urandom_range(1, burst_val ? 3 : 20);
        end
        out_stall <= burst_val;
        burst_left--;
      end
    end
  end

  task automatic send_corner(int x, int y, score_t s, bit fin);
    int gap;
    in_valid <= 1;
    in_x_pos <= coord_t'(x);
    in_y_pos <= coord_t'(y);
    in_corner_score <= s;
    in_final_corner <= fin;
    do @(posedge clk); while (in_stall);
    sent++;
    if ($urandom_range(0, 99) < 30) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic score_t pick_score();
    case ($urandom_range(0, 7))
      0: return score_t'(32'h8000_0000);
      1: return score_t'(32'h7fff_ffff);
      2, 3: return score_t'($urandom);
      default: return score_t'(int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  initial begin
    int y, rows, per_row, x;
    bit fin;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Ties to the left and above suppress; ties to the right and below do not.
    send_corner(0, 0, score_t'(32'h8000_0000), 0);
    send_corner(1, 0, score_t'(32'h8000_0000), 0);
    send_corner(2, 0, 5, 0);
    send_corner(4095, 0, score_t'(32'h7fff_ffff), 0);
    send_corner(1, 1, 5, 0);
    send_corner(3, 1, 5, 0);
    send_corner(3, 1, 9, 0);            // same x in a row is no neighbour
    send_corner(4094, 1, score_t'(32'h7fff_ffff), 0);
    send_corner(2, 2, 4, 0);
    send_corner(2, 4, 1, 0);            // skips a row, so the lower row is missing
    send_corner(3, 4, 1, 0);
    send_corner(2, 5, 1, 0);
    send_corner(10, 2, 7, 0);           // row number going back starts a new frame
    send_corner(11, 3, 7, 0);
    send_corner(12, 3, -1, 1);          // last corner flushes everything
    send_corner(4095, 4094, -7, 0);
    send_corner(4095, 4095, score_t'(32'h7fff_ffff), 0);
    send_corner(4094, 4095, score_t'(32'h7fff_ffff), 1);
    send_corner(0, 0, 0, 1);

    while (sent < 190) begin
      y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4088) : $urandom_range(0, 6);
      rows = $urandom_range(1, 7);
      for (int r = 0; r < rows; r++) begin
        // A rare long row overflows its capacity.
        per_row = ($urandom_range(0, 24) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 6);
        x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 8);
        for (int c = 0; c < per_row; c++) begin
          fin = (r == rows - 1) && (c == per_row - 1) && ($urandom_range(0, 9) < 7);
          send_corner(x, y, pick_score(), fin);
          x = x + $urandom_range(0, 3);
          if (x > 4095) x = 4095;
        end
        if ($urandom_range(0, 19) == 0 && y > 0) y = y - $urandom_range(1, y);
        else y = y + (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1);
        if (y > 4095) y = 4095;
      end
    end
    send_corner($urandom_range(0, 4095), 4095, pick_score(), 1);
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/cnms_pkg.sv
sv/cnms_ram.sv
sv/corner_nonmax_suppression_top.sv
bench/corner_nonmax_suppression_checker.sv
bench/corner_nonmax_suppression_top_test.sv
